/* src/decimal_string_to_fixed_top_macros.svh */
// Assertion macros for the checker module of the string-to-fixed block.
`ifndef DECIMAL_STRING_TO_FIXED_TOP_MACROS_SVH
`define DECIMAL_STRING_TO_FIXED_TOP_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define DSTF_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define DSTF_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dstf_pkg.sv */
// Shared types, constants and functions of the decimal string to fixed-point converter.
package dstf_pkg;

    localparam int MAX_CHARS_DEF   = 20;
    localparam int FRAC_DIGITS_DEF = 4;

    // Magnitude is held unsigned below 2^63
    localparam int MAG_W  = 63;
    localparam int SUM_W  = MAG_W + 5;
    localparam int POW_W  = 20;
    localparam int TERM_W = POW_W + 4;
    localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_FORMAT = 2'd1,
        ST_TOO_LONG   = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CK_SIGN,
        CK_POINT,
        CK_DIGIT,
        CK_OTHER
    } char_kind_t;

    typedef struct packed {
        logic fmt_err;
        logic point_seen;
        logic prev_digit;
        logic await_digit;
        logic neg;
        logic round_up;
        logic sat;
    } flags_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] value;
    } result_t;

    // Power of ten; called with elaboration-time arguments only
    function automatic logic [POW_W-1:0] pow10(input int n);
        logic [POW_W-1:0] p;
        p = POW_W'(1);
        for (int i = 0; i < n; i++) begin
            p = POW_W'(p * POW_W'(10));
        end
        return p;
    endfunction

endpackage

/* src/decimal_string_to_fixed_top.sv */
// Top level of the decimal string to fixed-point converter.
//
// Input stream: one ASCII character per transaction on s_tdata, s_tlast set on
// the final character of a string. Output stream: one transaction per string,
// m_tdata the signed value times 10^FRAC_DIGITS rounded half away from zero,
// m_tuser the status (0 valid, 1 bad format, 2 too long, 3 valid but saturated).
// A character is registered on acceptance and processed by the combinational
// parse step once it fires, which updates the running state and, for the final
// character, loads the result register. The result passes through the input
// register and the result register to m_tvalid. Throughput: one character
// per cycle while no final character waits (parse step: one scaled add).
// Non-final characters never wait on the output side. A final character waits
// in the input register while an earlier result is still unaccepted, and
// s_tready drops only then, so a stalled receiver holds the input one deep.
// Reset (aresetn low at a clock edge) clears the parse state and both
// valid flags; a string partly received is dropped.
module decimal_string_to_fixed_top #(
    parameter int MAX_CHARS   = dstf_pkg::MAX_CHARS_DEF,
    parameter int FRAC_DIGITS = dstf_pkg::FRAC_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] scaled_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int PW = $clog2(MAX_CHARS + 2);
    localparam int FW = $clog2(FRAC_DIGITS + 2);

    logic                       in_valid_reg;
    logic [7:0]                 in_char_reg;
    logic                       in_last_reg;
    logic [PW-1:0]              pos_reg;
    logic [PW-1:0]              pos_next;
    logic [FW-1:0]              frac_reg;
    logic [FW-1:0]              frac_next;
    logic [dstf_pkg::MAG_W-1:0] mag_reg;
    logic [dstf_pkg::MAG_W-1:0] mag_next;
    dstf_pkg::flags_t           flags_reg;
    dstf_pkg::flags_t           flags_next;
    dstf_pkg::result_t          result;
    logic                       out_valid_reg;
    dstf_pkg::status_t          out_status_reg;
    logic [63:0]                out_value_reg;
    logic                       out_free;
    logic                       fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || fire;

    dstf_step #(
        .MAX_CHARS   (MAX_CHARS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_step (
        .char_code  (in_char_reg),
        .last_char  (in_last_reg),
        .pos        (pos_reg),
        .frac_cnt   (frac_reg),
        .mag        (mag_reg),
        .flags      (flags_reg),
        .pos_next   (pos_next),
        .frac_next  (frac_next),
        .mag_next   (mag_next),
        .flags_next (flags_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Advance the parse state once per processed character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            frac_reg  <= '0;
            mag_reg   <= '0;
            flags_reg <= '0;
        end else if (fire) begin
            pos_reg   <= pos_next;
            frac_reg  <= frac_next;
            mag_reg   <= mag_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_last_reg) begin
            out_status_reg <= result.status;
            out_value_reg  <= result.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

/* src/dstf_step.sv */
// Per-character parse step: format checks, scaled accumulate, final rounding and sign.
module dstf_step #(
    parameter int MAX_CHARS   = dstf_pkg::MAX_CHARS_DEF,
    parameter int FRAC_DIGITS = dstf_pkg::FRAC_DIGITS_DEF,
    localparam int PW = $clog2(MAX_CHARS + 2),
    localparam int FW = $clog2(FRAC_DIGITS + 2),
    localparam int IW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1
) (
    input  logic [7:0]                  char_code,
    input  logic                        last_char,
    input  logic [PW-1:0]               pos,
    input  logic [FW-1:0]               frac_cnt,
    input  logic [dstf_pkg::MAG_W-1:0]  mag,
    input  dstf_pkg::flags_t            flags,
    output logic [PW-1:0]               pos_next,
    output logic [FW-1:0]               frac_next,
    output logic [dstf_pkg::MAG_W-1:0]  mag_next,
    output dstf_pkg::flags_t            flags_next,
    output dstf_pkg::result_t           result
);

    logic [dstf_pkg::POW_W-1:0]  pow_tab [2**IW];
    logic [dstf_pkg::POW_W-1:0]  pow_sel;
    logic [IW-1:0]               pow_idx;
    logic [FW:0]                 idx_wide;
    logic [3:0]                  digit;
    logic                        is_digit;
    logic                        frac_keep;
    logic [dstf_pkg::TERM_W-1:0] term;
    logic [dstf_pkg::SUM_W-1:0]  base;
    logic [dstf_pkg::SUM_W-1:0]  sum;
    logic                        over;
    dstf_pkg::char_kind_t        kind;

    // Digit weight: 10^FRAC_DIGITS for integer digits, falling for fraction digits
    genvar g;
    generate
        for (g = 0; g < 2**IW; g++) begin : g_pow
            assign pow_tab[g] = (g <= FRAC_DIGITS) ? dstf_pkg::pow10(g) : '0;
        end
    endgenerate

    assign is_digit  = (char_code >= dstf_pkg::CH_ZERO) && (char_code <= dstf_pkg::CH_NINE);
    assign digit     = char_code[3:0];
    assign frac_keep = (frac_cnt < FW'(FRAC_DIGITS));
    assign idx_wide  = (FW + 1)'(FRAC_DIGITS - 1) - {1'b0, frac_cnt};
    assign pow_idx   = flags.point_seen ? idx_wide[IW-1:0] : IW'(FRAC_DIGITS);
    assign pow_sel   = pow_tab[pow_idx];
    assign term      = dstf_pkg::TERM_W'(digit) * dstf_pkg::TERM_W'(pow_sel);
    assign base      = flags.point_seen ? dstf_pkg::SUM_W'(mag)
                     : (dstf_pkg::SUM_W'(mag) << 3) + (dstf_pkg::SUM_W'(mag) << 1);
    assign sum       = base + dstf_pkg::SUM_W'(term);
    assign over      = sum > dstf_pkg::SUM_W'(dstf_pkg::MAG_LIMIT);

    always_comb begin
        if (char_code == dstf_pkg::CH_PLUS || char_code == dstf_pkg::CH_MINUS) begin
            kind = dstf_pkg::CK_SIGN;
        end else if (char_code == dstf_pkg::CH_POINT) begin
            kind = dstf_pkg::CK_POINT;
        end else if (is_digit) begin
            kind = dstf_pkg::CK_DIGIT;
        end else begin
            kind = dstf_pkg::CK_OTHER;
        end
    end

    always_comb begin
        logic                       push;
        logic [dstf_pkg::MAG_W-1:0] mag_fin;
        logic                       sat_fin;
        logic [63:0]                val;

        flags_next = flags;
        frac_next  = frac_cnt;
        mag_next   = mag;
        push       = 1'b0;

        if (flags.await_digit && !is_digit) begin
            flags_next.fmt_err = 1'b1;
        end
        flags_next.await_digit = 1'b0;

        case (kind)
            dstf_pkg::CK_SIGN: begin
                if (pos != '0 || last_char) begin
                    flags_next.fmt_err = 1'b1;
                end else if (char_code == dstf_pkg::CH_MINUS) begin
                    flags_next.neg = 1'b1;
                end
            end
            dstf_pkg::CK_POINT: begin
                if (flags.point_seen) begin
                    flags_next.fmt_err = 1'b1;
                end else begin
                    flags_next.point_seen = 1'b1;
                    if (!flags.prev_digit) begin
                        if (last_char) begin
                            flags_next.fmt_err = 1'b1;
                        end else begin
                            flags_next.await_digit = 1'b1;
                        end
                    end
                end
            end
            dstf_pkg::CK_DIGIT: begin
                if (!flags.point_seen) begin
                    push = 1'b1;
                end else if (frac_keep) begin
                    push      = 1'b1;
                    frac_next = frac_cnt + FW'(1);
                end else if (frac_cnt == FW'(FRAC_DIGITS)) begin
                    flags_next.round_up = (digit >= 4'd5);
                    frac_next           = frac_cnt + FW'(1);
                end
            end
            default: begin
                flags_next.fmt_err = 1'b1;
            end
        endcase
        flags_next.prev_digit = is_digit;

        // Accumulate in already-scaled form; clamp once past the limit
        if (push && !flags.sat) begin
            if (over) begin
                flags_next.sat = 1'b1;
                mag_next       = dstf_pkg::MAG_LIMIT;
            end else begin
                mag_next = sum[dstf_pkg::MAG_W-1:0];
            end
        end

        pos_next = (pos <= PW'(MAX_CHARS)) ? pos + PW'(1) : pos;

        // Round half up, then apply the sign
        mag_fin = mag_next;
        sat_fin = flags_next.sat;
        if (flags_next.round_up && !flags_next.sat) begin
            if (mag_next == dstf_pkg::MAG_LIMIT) begin
                sat_fin = 1'b1;
            end else begin
                mag_fin = mag_next + dstf_pkg::MAG_W'(1);
            end
        end
        val = {1'b0, mag_fin};
        if (flags_next.neg) begin
            val = 64'd0 - val;
        end

        if (pos_next > PW'(MAX_CHARS)) begin
            result.status = dstf_pkg::ST_TOO_LONG;
            result.value  = '0;
        end else if (flags_next.fmt_err) begin
            result.status = dstf_pkg::ST_BAD_FORMAT;
            result.value  = '0;
        end else begin
            result.status = sat_fin ? dstf_pkg::ST_SATURATED : dstf_pkg::ST_OK;
            result.value  = val;
        end

        // Start fresh after the final character
        if (last_char) begin
            flags_next = '0;
            frac_next  = '0;
            mag_next   = '0;
            pos_next   = '0;
        end
    end

endmodule

/* src/dstf_checker.sv */
// Port-level checker for the string-to-fixed converter, bound to its top level.
`include "decimal_string_to_fixed_top_macros.svh"

module dstf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    `DSTF_ASSERT_CLK(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `DSTF_ASSERT_RST(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled result changed")

    `DSTF_ASSERT_RST(a_err_zero, aclk, aresetn,
        m_tvalid && (m_tuser == dstf_pkg::ST_BAD_FORMAT
            || m_tuser == dstf_pkg::ST_TOO_LONG) |-> m_tdata == 64'd0,
        "error result carries a value")

    `DSTF_ASSERT_RST(a_no_min_int, aclk, aresetn,
        m_tvalid |-> m_tdata != 64'h8000_0000_0000_0000,
        "value beyond saturation limit")

    `DSTF_ASSERT_RST(a_stall_cause, aclk, aresetn,
        !s_tready |-> m_tvalid && !m_tready,
        "input stalled without output backpressure")

endmodule

bind decimal_string_to_fixed_top dstf_checker u_dstf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
